// ===== hdl/prefixed_secret_text_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the prefixed secret text decoder
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PREFIXED_SECRET_TEXT_DECODER_ASSERT_SVH
`define PREFIXED_SECRET_TEXT_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PSTD_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define PSTD_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define PSTD_ASSERT_IMPL(label, clk, rst, cond, prop)
`define PSTD_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hdl/pstd_pkg.sv =====
// ----------------------------------------------------------------------------
// pstd_pkg
// Types, constants and character decode functions of the text decoder.
// ----------------------------------------------------------------------------
package pstd_pkg;

  typedef enum logic [1:0] {
    MODE_B32   = 2'd0,
    MODE_HEX   = 2'd1,
    MODE_B64   = 2'd2,
    MODE_UNDEC = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
    logic       empty_text;
  } in_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic        run_last;
    logic        decode_error;
    logic [1:0]  encoding_kind;
    logic [10:0] byte_total;
  } out_t;

  typedef struct packed {
    logic [39:0] acc;
    logic [3:0]  fill;
    logic [3:0]  data_chars;
    logic        in_pad;
    logic        err;
  } grp_t;

  typedef struct packed {
    logic [4:0][7:0] bytes;
    logic [2:0]      n;
    logic            err;
  } fin_t;

  localparam logic [6:0]  VAL_PAD    = 7'd64;
  localparam logic [6:0]  VAL_BAD    = 7'd65;
  localparam logic [4:0]  HEX_BAD    = 5'd16;
  localparam logic [7:0]  CH_PAD     = 8'h3d;
  localparam logic [31:0] PREFIX_HEX = 32'h6865_783a;
  localparam logic [31:0] PREFIX_B64 = 32'h6236_343a;
  localparam logic [10:0] CAP_RESET  = 11'd64;
  localparam logic        REG_CAP    = 1'b0;
  localparam logic [3:0]  GRP_B32    = 4'd8;
  localparam logic [3:0]  GRP_B64    = 4'd4;

  function automatic logic [6:0] group_value(logic [7:0] c, logic b64);
    logic [6:0] v;
    v = VAL_BAD;
    if (c == CH_PAD) begin
      v = VAL_PAD;
    end else if (b64) begin
      if (c >= 8'h41 && c <= 8'h5a) v = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
      else if (c == 8'h2b) v = 7'd62;
      else if (c == 8'h2f) v = 7'd63;
    end else begin
      if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h61);
      else if (c >= 8'h41 && c <= 8'h5a) v = 7'(c - 8'h41);
      else if (c >= 8'h32 && c <= 8'h37) v = 7'(c - 8'h32 + 8'd26);
    end
    return v;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  // one base32/base64 character into the group, no flush here
  function automatic grp_t grp_char(grp_t s, logic [7:0] c, logic b64);
    grp_t       r;
    logic [6:0] v;
    logic       short_ok;
    r = s;
    v = group_value(c, b64);
    short_ok = b64 ? (s.fill == 4'd2 || s.fill == 4'd3)
                   : (s.fill == 4'd2 || s.fill == 4'd4 || s.fill == 4'd5 || s.fill == 4'd7);
    if (!s.err) begin
      if (s.in_pad) begin
        if (v != VAL_PAD) r.err = 1'b1;
        else r.fill = s.fill + 4'd1;
      end else if (v == VAL_PAD) begin
        if (!short_ok) begin
          r.err = 1'b1;
        end else begin
          r.in_pad     = 1'b1;
          r.data_chars = s.fill;
          r.fill       = s.fill + 4'd1;
        end
      end else if (v == VAL_BAD) begin
        r.err = 1'b1;
      end else begin
        r.acc        = b64 ? {s.acc[33:0], v[5:0]} : {s.acc[34:0], v[4:0]};
        r.data_chars = s.fill + 4'd1;
        r.fill       = s.fill + 4'd1;
      end
    end
    return r;
  endfunction

  // feed the held prefix characters, oldest first, as base32
  function automatic grp_t replay(logic [31:0] p, logic [2:0] k, grp_t s);
    grp_t       r;
    logic [7:0] ch;
    r = s;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < k) begin
        ch = 8'(p >> {k - 3'(i) - 3'd1, 3'b000});
        r  = grp_char(r, ch, 1'b0);
      end
    end
    return r;
  endfunction

  function automatic fin_t grp_finish(logic [39:0] acc, logic [3:0] m, logic b64,
                                      logic [10:0] emitted, logic [10:0] lim);
    fin_t        r;
    logic [39:0] bits;
    logic        low_bad;
    r.n     = 3'd0;
    bits    = acc;
    low_bad = 1'b0;
    if (b64) begin
      unique case (m)
        4'd2:    begin r.n = 3'd1; bits = acc << 12; end
        4'd3:    begin r.n = 3'd2; bits = acc << 6; end
        4'd4:    begin r.n = 3'd3; bits = acc; end
        default: r.n = 3'd0;
      endcase
      r.bytes = {bits[23:16], bits[15:8], bits[7:0], 16'h0000};
    end else begin
      unique case (m)
        4'd2:    begin r.n = 3'd1; bits = acc << 30; low_bad = |acc[1:0]; end
        4'd4:    begin r.n = 3'd2; bits = acc << 20; low_bad = |acc[3:0]; end
        4'd5:    begin r.n = 3'd3; bits = acc << 15; low_bad = acc[0]; end
        4'd7:    begin r.n = 3'd4; bits = acc << 5;  low_bad = |acc[2:0]; end
        4'd8:    begin r.n = 3'd5; bits = acc; end
        default: r.n = 3'd0;
      endcase
      r.bytes = {bits[39:32], bits[31:24], bits[23:16], bits[15:8], bits[7:0]};
    end
    r.err = (r.n == 3'd0) || ({1'b0, emitted} + 12'(r.n) > {1'b0, lim}) || low_bad;
    if (r.err) r.n = 3'd0;
    return r;
  endfunction

endpackage

// ===== hdl/prefixed_secret_text_decoder.sv =====
// ----------------------------------------------------------------------------
// prefixed_secret_text_decoder
// Decodes a hex, base64 or base32 text stream into bytes plus a final status.
// ----------------------------------------------------------------------------
// One character is taken per clock while char_stall is low. Its whole decode
// runs in the cycle it is accepted and lands in a result buffer that holds up
// to five bytes and the status. A character that yields more than one result
// keeps the char side stalled while the buffer drains one beat per cycle, as
// long as result_stall is low. The next character is accepted in the cycle the
// last buffered beat is taken.
module prefixed_secret_text_decoder
  import pstd_pkg::*;
#(
  parameter int CAPACITY_LIMIT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  in_t         char_beat,
  output logic        result_valid,
  input  logic        result_stall,
  output out_t        result_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [10:0] LIMIT_CLIP = (CAPACITY_LIMIT > 2047) ? 11'h7ff : 11'(CAPACITY_LIMIT);

  logic [10:0] out_capacity;
  logic [31:0] prefix;
  logic [2:0]  chars;
  mode_t       mode;
  grp_t        grp;
  logic        pend;
  logic [3:0]  hinib;
  logic [10:0] emitted;

  logic [31:0] prefix_next;
  logic [2:0]  chars_next;
  mode_t       mode_next;
  grp_t        grp_next;
  logic        pend_next;
  logic [3:0]  hinib_next;
  logic [10:0] emitted_next;

  // result buffer
  logic            ob_valid;
  logic [4:0][7:0] ob_bytes;
  logic [2:0]      ob_n;
  logic            ob_status;
  logic            ob_err;
  logic [1:0]      ob_enc;
  logic [10:0]     ob_total;
  logic [2:0]      ob_idx;

  logic [10:0]     lim;
  logic            accept;
  logic            take;
  logic            take_last;
  logic [2:0]      ob_nres;
  logic [4:0][7:0] bytes_next;
  logic [2:0]      n_next;
  logic            is_end;
  logic            hex_emit;
  logic [7:0]      hex_byte;
  logic [4:0]      hv;
  logic            need_fin;
  logic            b64;
  fin_t            fin;

  assign lim = (out_capacity < LIMIT_CLIP) ? out_capacity : LIMIT_CLIP;

  always_comb begin
    prefix_next  = prefix;
    chars_next   = chars;
    mode_next    = mode;
    grp_next     = grp;
    pend_next    = pend;
    hinib_next   = hinib;
    hex_emit     = 1'b0;
    hex_byte     = 8'h00;
    hv           = hex_value(char_beat.in_char);
    is_end       = char_beat.end_of_text || char_beat.empty_text;
    if (!char_beat.empty_text) begin
      if (mode == MODE_UNDEC) begin
        prefix_next = {prefix[23:0], char_beat.in_char};
        chars_next  = chars + 3'd1;
        if (chars_next >= 3'd4) begin
          if (prefix_next == PREFIX_HEX) begin
            mode_next = MODE_HEX;
          end else if (prefix_next == PREFIX_B64) begin
            mode_next = MODE_B64;
          end else begin
            mode_next = MODE_B32;
            grp_next  = replay(prefix_next, chars_next, grp);
          end
        end
      end else if (!grp.err) begin
        if (mode == MODE_HEX) begin
          if (hv == HEX_BAD) begin
            grp_next.err = 1'b1;
          end else if (!pend) begin
            hinib_next = hv[3:0];
            pend_next  = 1'b1;
          end else begin
            pend_next = 1'b0;
            if ({1'b0, emitted} + 12'd1 > {1'b0, lim}) begin
              grp_next.err = 1'b1;
            end else begin
              hex_emit = 1'b1;
              hex_byte = {hinib, hv[3:0]};
            end
          end
        end else begin
          grp_next = grp_char(grp, char_beat.in_char, mode == MODE_B64);
        end
      end
    end
    // a string that ends before the prefix is settled falls back to base32
    if (is_end && mode_next == MODE_UNDEC) begin
      mode_next = MODE_B32;
      grp_next  = replay(prefix_next, chars_next, grp_next);
    end
    if (is_end && !grp_next.err && mode_next == MODE_HEX && pend_next) begin
      pend_next = 1'b0;
      if ({1'b0, emitted} + 12'd1 > {1'b0, lim}) begin
        grp_next.err = 1'b1;
      end else begin
        hex_emit = 1'b1;
        hex_byte = {hinib_next, 4'h0};
      end
    end
    b64      = (mode_next == MODE_B64);
    need_fin = !grp_next.err && (mode_next == MODE_B32 || mode_next == MODE_B64) &&
               ((grp_next.fill == (b64 ? GRP_B64 : GRP_B32)) ||
                (is_end && grp_next.fill != 4'd0));
    fin = grp_finish(grp_next.acc, grp_next.data_chars, b64, emitted, lim);
    if (need_fin) begin
      grp_next.err        = fin.err;
      grp_next.acc        = '0;
      grp_next.fill       = '0;
      grp_next.data_chars = '0;
      grp_next.in_pad     = 1'b0;
    end
    n_next       = hex_emit ? 3'd1 : (need_fin ? fin.n : 3'd0);
    bytes_next   = hex_emit ? {hex_byte, 32'h0} : fin.bytes;
    emitted_next = emitted + 11'(n_next);
  end

  assign ob_nres   = ob_n + 3'(ob_status);
  assign take      = ob_valid && !result_stall;
  assign take_last = take && (ob_idx == ob_nres - 3'd1);
  assign char_stall = ob_valid && !take_last;
  assign accept    = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
      prefix       <= '0;
      chars        <= '0;
      mode         <= MODE_UNDEC;
      grp          <= '0;
      pend         <= 1'b0;
      hinib        <= '0;
      emitted      <= '0;
      ob_valid     <= 1'b0;
      ob_idx       <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_CAP) begin
        out_capacity <= pwdata[10:0];
      end
      if (accept) begin
        ob_valid  <= is_end || (n_next != 3'd0);
        ob_idx    <= '0;
        ob_bytes  <= bytes_next;
        ob_n      <= n_next;
        ob_status <= is_end;
        ob_err    <= grp_next.err;
        ob_enc    <= grp_next.err ? MODE_B32 : mode_next;
        ob_total  <= grp_next.err ? 11'd0 : emitted_next;
        if (is_end) begin
          prefix  <= '0;
          chars   <= '0;
          mode    <= MODE_UNDEC;
          grp     <= '0;
          pend    <= 1'b0;
          hinib   <= '0;
          emitted <= '0;
        end else begin
          prefix  <= prefix_next;
          chars   <= chars_next;
          mode    <= mode_next;
          grp     <= grp_next;
          pend    <= pend_next;
          hinib   <= hinib_next;
          emitted <= emitted_next;
        end
      end else if (take) begin
        if (take_last) ob_valid <= 1'b0;
        else ob_idx <= ob_idx + 3'd1;
      end
    end
  end

  always_comb begin
    result_beat               = '0;
    result_beat.item_kind     = (ob_idx >= ob_n);
    result_beat.run_last      = (ob_idx == ob_nres - 3'd1);
    if (result_beat.item_kind) begin
      result_beat.decode_error  = ob_err;
      result_beat.encoding_kind = ob_enc;
      result_beat.byte_total    = ob_total;
    end else begin
      unique case (ob_idx)
        3'd0:    result_beat.data_byte = ob_bytes[4];
        3'd1:    result_beat.data_byte = ob_bytes[3];
        3'd2:    result_beat.data_byte = ob_bytes[2];
        3'd3:    result_beat.data_byte = ob_bytes[1];
        3'd4:    result_beat.data_byte = ob_bytes[0];
        default: result_beat.data_byte = 8'h00;
      endcase
    end
  end

  assign result_valid = ob_valid;
  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_CAP) ? {21'b0, out_capacity} : 32'h0;

`include "prefixed_secret_text_decoder_assert.svh"

  `PSTD_ASSERT_IMPL(a_accept_frees_buffer, clk, rst,
    char_valid && !char_stall && result_valid, !result_stall && result_beat.run_last)
  `PSTD_ASSERT_IMPL(a_status_is_last, clk, rst,
    result_valid && result_beat.item_kind, result_beat.run_last)
  `PSTD_ASSERT_IMPL(a_error_status, clk, rst,
    result_valid && result_beat.item_kind && result_beat.decode_error,
    result_beat.byte_total == 11'd0 && result_beat.encoding_kind == MODE_B32)
  `PSTD_ASSERT_NEXT(a_end_clears_state, clk, rst,
    char_valid && !char_stall && (char_beat.end_of_text || char_beat.empty_text),
    mode == MODE_UNDEC && emitted == 11'd0)

endmodule
